// ----- design/rhd_pkg.sv -----
// Shared types and constants for the RTP H.264 depacketizer.
// Used by rhd_parse, rhd_emit, the top level and the testbench.
package rhd_pkg;

  localparam int unsigned FIXED_HEADER_BYTES = 12;
  localparam int unsigned POS_W              = 7;
  localparam logic [POS_W-1:0] BYTE_POS_MAX  = 7'd127;

  localparam logic [4:0] NAL_TYPE_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_TYPE_FU_A       = 5'd28;

  // Start code 00 00 00 01: index of the final byte and its value
  localparam logic [1:0] SC_LAST_IDX  = 2'd3;
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SINGLE  = 2'd1,
    KIND_FU_HDR  = 2'd2,
    KIND_FU_DATA = 2'd3
  } kind_t;

  // Results caused by one packet byte, in emission order:
  // optional marker, optional start code, optional data byte.
  typedef struct packed {
    logic       has_mark;
    logic       mark_abort;
    logic       mark_gap;
    logic       mark_last;
    logic       has_sc;
    logic       has_byte;
    logic [7:0] data;
    logic       data_last;
  } desc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       nal_first;
    logic       nal_last;
    logic       nal_abort;
    logic       seq_gap;
    logic       run_last;
  } res_t;

endpackage

// ----- design/rhd_parse.sv -----
// Packet byte parser: RTP header skip, sequence check and NAL / FU-A decode.
// Produces one result descriptor per accepted byte; depends on rhd_pkg.
module rhd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          pkt_byte,
  input  logic                pkt_last,
  output rhd_pkg::desc_t      desc,
  output logic                desc_has
);

  logic [rhd_pkg::POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [3:0]  csrc_r, csrc_nxt;
  logic [7:0]  seq_hi_r, seq_hi_nxt;
  logic [7:0]  seq_lo_r, seq_lo_nxt;
  logic [15:0] prev_seq_r, prev_seq_nxt;
  logic        no_pkt_r, no_pkt_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  rhd_pkg::kind_t kind_r, kind_nxt;
  logic        frag_open_r, frag_open_nxt;
  logic        fu_end_r, fu_end_nxt;

  logic [rhd_pkg::POS_W-1:0] hs;
  logic [15:0] seq;
  logic        gap, single, ab, e_bit;

  // Header latches and decode of the current byte
  always_comb begin
    csrc_nxt   = csrc_r;
    seq_hi_nxt = seq_hi_r;
    seq_lo_nxt = seq_lo_r;

    if (byte_pos_r == '0) csrc_nxt = pkt_byte[3:0];
    if (byte_pos_r == 7'd2) seq_hi_nxt = pkt_byte;
    if (byte_pos_r == 7'd3) seq_lo_nxt = pkt_byte;

    hs     = 7'(rhd_pkg::FIXED_HEADER_BYTES) + {1'b0, csrc_nxt, 2'b00};
    seq    = {seq_hi_nxt, seq_lo_nxt};
    gap    = !no_pkt_r && (seq != prev_seq_r + 16'd1);
    single = pkt_byte[4:0] <= rhd_pkg::NAL_TYPE_SINGLE_MAX;
    ab     = frag_open_r && (gap || single);
    e_bit  = pkt_byte[6];
  end

  // Next state
  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    prev_seq_nxt  = prev_seq_r;
    no_pkt_nxt    = no_pkt_r;
    hdr_nxt       = hdr_r;
    kind_nxt      = kind_r;
    frag_open_nxt = frag_open_r;
    fu_end_nxt    = fu_end_r;

    if (byte_pos_r == hs) begin
      // First payload byte: sequence check and NAL header
      prev_seq_nxt = seq;
      no_pkt_nxt   = 1'b0;
      if (ab) frag_open_nxt = 1'b0;
      if (single) begin
        kind_nxt = rhd_pkg::KIND_SINGLE;
      end else if (pkt_byte[4:0] == rhd_pkg::NAL_TYPE_FU_A) begin
        hdr_nxt  = pkt_byte;
        kind_nxt = rhd_pkg::KIND_FU_HDR;
      end else begin
        kind_nxt = rhd_pkg::KIND_NONE;
      end
    end else if (byte_pos_r > hs) begin
      case (kind_r)
        rhd_pkg::KIND_FU_HDR: begin
          if (pkt_byte[7]) begin
            frag_open_nxt = !(e_bit && pkt_last);
            fu_end_nxt    = e_bit;
            kind_nxt      = rhd_pkg::KIND_FU_DATA;
          end else if (frag_open_r) begin
            fu_end_nxt = e_bit;
            kind_nxt   = rhd_pkg::KIND_FU_DATA;
            if (e_bit && pkt_last) frag_open_nxt = 1'b0;
          end else begin
            kind_nxt = rhd_pkg::KIND_NONE;
          end
        end
        rhd_pkg::KIND_FU_DATA: begin
          if (pkt_last && fu_end_r) frag_open_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (pkt_last) begin
      byte_pos_nxt = '0;
      kind_nxt     = rhd_pkg::KIND_NONE;
      fu_end_nxt   = 1'b0;
    end else if (byte_pos_r < rhd_pkg::BYTE_POS_MAX) begin
      byte_pos_nxt = byte_pos_r + 7'd1;
    end
  end

  // Result descriptor
  always_comb begin
    desc = '0;

    if (byte_pos_r == hs) begin
      if (gap || ab) begin
        desc.has_mark   = 1'b1;
        desc.mark_abort = ab;
        desc.mark_gap   = gap;
      end
      if (single) begin
        desc.has_sc    = 1'b1;
        desc.has_byte  = 1'b1;
        desc.data      = pkt_byte;
        desc.data_last = pkt_last;
      end
    end else if (byte_pos_r > hs) begin
      case (kind_r)
        rhd_pkg::KIND_SINGLE: begin
          desc.has_byte  = 1'b1;
          desc.data      = pkt_byte;
          desc.data_last = pkt_last;
        end
        rhd_pkg::KIND_FU_HDR: begin
          if (pkt_byte[7]) begin
            // Fresh start bit: abort any open fragment, rebuild the NAL header
            desc.has_mark   = frag_open_r;
            desc.mark_abort = frag_open_r;
            desc.has_sc     = 1'b1;
            desc.has_byte   = 1'b1;
            desc.data       = {hdr_r[7:5], pkt_byte[4:0]};
            desc.data_last  = e_bit && pkt_last;
          end else if (frag_open_r && e_bit && pkt_last) begin
            desc.has_mark  = 1'b1;
            desc.mark_last = 1'b1;
          end
        end
        rhd_pkg::KIND_FU_DATA: begin
          desc.has_byte  = 1'b1;
          desc.data      = pkt_byte;
          desc.data_last = pkt_last && fu_end_r;
        end
        default: begin
        end
      endcase
    end

    desc_has = desc.has_mark || desc.has_sc || desc.has_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      csrc_r      <= '0;
      seq_hi_r    <= '0;
      seq_lo_r    <= '0;
      prev_seq_r  <= '0;
      no_pkt_r    <= 1'b1;
      hdr_r       <= '0;
      kind_r      <= rhd_pkg::KIND_NONE;
      frag_open_r <= 1'b0;
      fu_end_r    <= 1'b0;
    end else if (accept) begin
      byte_pos_r  <= byte_pos_nxt;
      csrc_r      <= csrc_nxt;
      seq_hi_r    <= seq_hi_nxt;
      seq_lo_r    <= seq_lo_nxt;
      prev_seq_r  <= prev_seq_nxt;
      no_pkt_r    <= no_pkt_nxt;
      hdr_r       <= hdr_nxt;
      kind_r      <= kind_nxt;
      frag_open_r <= frag_open_nxt;
      fu_end_r    <= fu_end_nxt;
    end
  end

endmodule

// ----- design/rhd_emit.sv -----
// Result sequencer: holds one descriptor and issues its results one per cycle
// while the output is not stalled, into the output register. Depends on rhd_pkg.
module rhd_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  rhd_pkg::desc_t  load_desc,
  output logic            ready,
  output logic            res_valid,
  output rhd_pkg::res_t   res,
  input  logic            res_stall
);

  rhd_pkg::desc_t desc_r, desc_nxt;
  logic       pend_mark_r, pend_mark_nxt;
  logic       pend_sc_r, pend_sc_nxt;
  logic       pend_byte_r, pend_byte_nxt;
  logic [1:0] sc_idx_r, sc_idx_nxt;
  logic       res_valid_r, res_valid_nxt;
  rhd_pkg::res_t res_r, res_nxt;

  logic busy, fire, cur_last;
  rhd_pkg::res_t cur;

  assign busy = pend_mark_r || pend_sc_r || pend_byte_r;
  assign fire = busy && (!res_valid_r || !res_stall);

  always_comb begin
    cur = '0;
    if (pend_mark_r) begin
      cur.nal_last  = desc_r.mark_last;
      cur.nal_abort = desc_r.mark_abort;
      cur.seq_gap   = desc_r.mark_gap;
      cur_last      = !pend_sc_r && !pend_byte_r;
    end else if (pend_sc_r) begin
      cur.data       = (sc_idx_r == rhd_pkg::SC_LAST_IDX) ? rhd_pkg::SC_LAST_BYTE : 8'h00;
      cur.data_valid = 1'b1;
      cur.nal_first  = (sc_idx_r == 2'd0);
      cur_last       = (sc_idx_r == rhd_pkg::SC_LAST_IDX) && !pend_byte_r;
    end else begin
      cur.data       = desc_r.data;
      cur.data_valid = 1'b1;
      cur.nal_last   = desc_r.data_last;
      cur_last       = 1'b1;
    end
    cur.run_last = cur_last;
  end

  assign ready = !busy || (fire && cur_last);

  always_comb begin
    desc_nxt      = desc_r;
    pend_mark_nxt = pend_mark_r;
    pend_sc_nxt   = pend_sc_r;
    pend_byte_nxt = pend_byte_r;
    sc_idx_nxt    = sc_idx_r;
    res_valid_nxt = res_valid_r && res_stall;
    res_nxt       = res_r;

    if (fire) begin
      res_valid_nxt = 1'b1;
      res_nxt       = cur;
      if (pend_mark_r) begin
        pend_mark_nxt = 1'b0;
      end else if (pend_sc_r) begin
        sc_idx_nxt = sc_idx_r + 2'd1;
        if (sc_idx_r == rhd_pkg::SC_LAST_IDX) pend_sc_nxt = 1'b0;
      end else begin
        pend_byte_nxt = 1'b0;
      end
    end

    if (load) begin
      desc_nxt      = load_desc;
      pend_mark_nxt = load_desc.has_mark;
      pend_sc_nxt   = load_desc.has_sc;
      pend_byte_nxt = load_desc.has_byte;
      sc_idx_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_mark_r <= 1'b0;
      pend_sc_r   <= 1'b0;
      pend_byte_r <= 1'b0;
      sc_idx_r    <= 2'd0;
      res_valid_r <= 1'b0;
    end else begin
      pend_mark_r <= pend_mark_nxt;
      pend_sc_r   <= pend_sc_nxt;
      pend_byte_r <= pend_byte_nxt;
      sc_idx_r    <= sc_idx_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- design/rtp_h264_depacketizer.sv -----
// RTP H.264 depacketizer (single NAL and FU-A) to an Annex-B byte stream.
// Each descriptor is registered in the result sequencer, each result in the
// output register. Throughput: 1 byte per cycle when not stalled; a byte that
// opens a NAL unit causes up to 6 results (marker, 4 start-code bytes, header)
// issued one per cycle unless the output stalls; in_stall holds until the last.
// Reset: synchronous, active low; clears parser state and empties the output.
module rtp_h264_depacketizer (
  input  logic       clk,
  input  logic       rst_n,
  // Packet byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pkt_byte,
  input  logic       in_pkt_last,
  // Annex-B result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_nal_first,
  output logic       out_nal_last,
  output logic       out_nal_abort,
  output logic       out_seq_gap,
  output logic       out_run_last
);

  logic           seq_ready;
  logic           in_accept;
  rhd_pkg::desc_t desc;
  logic           desc_has;
  rhd_pkg::res_t  res;

  // Take a new byte whenever the sequencer is free or issues its final
  // result this cycle; a byte with no results just advances parser state.
  assign in_stall  = !seq_ready;
  assign in_accept = in_valid && seq_ready;

  rhd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .pkt_byte (in_pkt_byte),
    .pkt_last (in_pkt_last),
    .desc     (desc),
    .desc_has (desc_has)
  );

  // Load the descriptor only when the byte actually produces a transaction
  rhd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept && desc_has),
    .load_desc (desc),
    .ready     (seq_ready),
    .res_valid (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  // Unpack the registered result onto the field ports
  assign out_out_byte  = res.data;
  assign out_out_valid = res.data_valid;
  assign out_nal_first = res.nal_first;
  assign out_nal_last  = res.nal_last;
  assign out_nal_abort = res.nal_abort;
  assign out_seq_gap   = res.seq_gap;
  assign out_run_last  = res.run_last;

endmodule

// ----- design/rhd_checker.sv -----
// Port-level checker for rtp_h264_depacketizer, attached by bind.
// Sees the top-level ports only; depends on nothing else.
module rhd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_out_byte,
  input logic       out_out_valid,
  input logic       out_nal_first,
  input logic       out_nal_abort,
  input logic       out_seq_gap,
  input logic       out_run_last
);

  // A stalled result transaction holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte) && $stable(out_run_last))
    else $error("stalled result changed");

  // A NAL unit opens on a zero start-code byte, never the last of its run
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nal_first |-> out_out_valid && out_out_byte == 8'h00 && !out_run_last)
    else $error("bad start of NAL unit");

  // Gap and abort flags ride on marker-only results
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_seq_gap || out_nal_abort) |-> !out_out_valid && !out_nal_first)
    else $error("gap or abort on a data result");

  // After the first start-code byte the next result is another zero byte
  a_sc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_nal_first |=>
      !out_valid || (out_out_valid && out_out_byte == 8'h00 && !out_nal_first))
    else $error("start code broken");

endmodule

bind rtp_h264_depacketizer rhd_checker u_rhd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_out_byte  (out_out_byte),
  .out_out_valid (out_out_valid),
  .out_nal_first (out_nal_first),
  .out_nal_abort (out_nal_abort),
  .out_seq_gap   (out_seq_gap),
  .out_run_last  (out_run_last)
);

// ----- tb/sv/rtp_h264_depacketizer_tb.sv -----
// Self-checking testbench for rtp_h264_depacketizer: RTP packet bytes in, Annex-B stream out.
// Depends on rhd_pkg for the result struct, packet kinds and header constants;
// it predicts every result in its own model and compares each field.
module rtp_h264_depacketizer_tb;

  // Bit fields of the NAL and FU headers
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_START_BIT  = 8'h80;
  localparam logic [7:0] FU_END_BIT    = 8'h40;
  localparam logic [7:0] F_NRI_MASK    = 8'hE0;
  localparam logic [7:0] CC_MASK       = 8'h0F;

  localparam int IDLE_PCT        = 29;
  localparam int PLANNED_ITEMS   = 360;
  localparam int CALM_FROM       = 120;  // accepted bytes that open the stretch without idling
  localparam int CALM_TO         = 240;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic       hold;  // no byte: pause until the stream has caught up
    logic [7:0] data;
    logic       eop;
  } pkt_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_pkt_byte = 8'h00;
  logic       in_pkt_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_out_valid;
  logic       out_nal_first;
  logic       out_nal_last;
  logic       out_nal_abort;
  logic       out_seq_gap;
  logic       out_run_last;

  rtp_h264_depacketizer uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pkt_byte   (in_pkt_byte),
    .in_pkt_last   (in_pkt_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_out_byte  (out_out_byte),
    .out_out_valid (out_out_valid),
    .out_nal_first (out_nal_first),
    .out_nal_last  (out_nal_last),
    .out_nal_abort (out_nal_abort),
    .out_seq_gap   (out_seq_gap),
    .out_run_last  (out_run_last)
  );

  always #6 clk = ~clk;

  // Stimulus and expectation stores
  pkt_item_t      pkt_items[$];        // packet bytes waiting for the driver
  logic [7:0]     frame_bytes[$];      // packet under construction
  rhd_pkg::res_t  nal_burst[$];        // results of the byte being predicted
  rhd_pkg::res_t  annexb_expected[$];  // predicted stream, oldest first
  logic [15:0]    tx_seq;
  int             planned_bytes = 0;

  // Predictor state
  logic [6:0]     pkt_pos = '0;
  logic [3:0]     csrc_words = '0;
  logic [7:0]     seq_hi = '0;
  logic [7:0]     seq_lo = '0;
  logic [15:0]    last_seq = '0;
  logic           first_pkt = 1'b1;
  logic [7:0]     fu_indicator = '0;
  rhd_pkg::kind_t kind = rhd_pkg::KIND_NONE;
  logic           frag_open = 1'b0;
  logic           end_bit_seen = 1'b0;

  // Handshake bookkeeping
  logic          in_taken = 1'b0;
  logic          drain_wait = 1'b0;
  int            bytes_taken = 0;
  int            quiet_cycles = 0;
  int            mismatches = 0;
  logic          calm;
  pkt_item_t     next_item;
  rhd_pkg::res_t want_res;

  assign calm = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  task automatic note(input logic [7:0] data, input logic valid, input logic is_first,
                      input logic is_last, input logic drop, input logic gap);
    rhd_pkg::res_t r;
    r.data       = data;
    r.data_valid = valid;
    r.nal_first  = is_first;
    r.nal_last   = is_last;
    r.nal_abort  = drop;
    r.seq_gap    = gap;
    r.run_last   = 1'b0;
    nal_burst.insert(nal_burst.size(), r);
  endtask

  task automatic add_start_code();
    for (int k = 0; k < 4; k++)
      note((k == rhd_pkg::SC_LAST_IDX) ? rhd_pkg::SC_LAST_BYTE : 8'h00, 1'b1, k == 0,
           1'b0, 1'b0, 1'b0);
  endtask

  // Advance the depacketizer model by one accepted byte and queue what it emits.
  task automatic depacketize_byte(input logic [7:0] b, input logic eop);
    logic [6:0]    pos;
    int            hdr_len;
    logic [15:0]   seq_no;
    logic          gap;
    logic          ab;
    logic          e;
    logic          fin;
    rhd_pkg::res_t r;
    pos = pkt_pos;
    nal_burst.delete();
    if (pos == 0) csrc_words = 4'(b & CC_MASK);
    if (pos == 2) seq_hi = b;
    if (pos == 3) seq_lo = b;
    hdr_len = int'(rhd_pkg::FIXED_HEADER_BYTES) + 4 * int'(csrc_words);

    if (pos == hdr_len) begin
      // First payload byte: sequence check, abort of an open fragment, NAL type
      seq_no = {seq_hi, seq_lo};
      gap = !first_pkt && (seq_no != last_seq + 16'd1);
      ab = frag_open && (gap || (b[4:0] <= rhd_pkg::NAL_TYPE_SINGLE_MAX));
      last_seq = seq_no;
      first_pkt = 1'b0;
      if (gap || ab) note(8'h00, 1'b0, 1'b0, 1'b0, ab, gap);
      if (ab) frag_open = 1'b0;
      if (b[4:0] <= rhd_pkg::NAL_TYPE_SINGLE_MAX) begin
        add_start_code();
        note(b, 1'b1, 1'b0, eop, 1'b0, 1'b0);
        kind = rhd_pkg::KIND_SINGLE;
      end else if (b[4:0] == rhd_pkg::NAL_TYPE_FU_A) begin
        fu_indicator = b;
        kind = rhd_pkg::KIND_FU_HDR;
      end else begin
        kind = rhd_pkg::KIND_NONE;
      end
    end else if (pos > hdr_len) begin
      case (kind)
        rhd_pkg::KIND_SINGLE: note(b, 1'b1, 1'b0, eop, 1'b0, 1'b0);
        rhd_pkg::KIND_FU_HDR: begin
          e = (b & FU_END_BIT) != 8'h00;
          if ((b & FU_START_BIT) != 8'h00) begin
            if (frag_open) note(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
            add_start_code();
            note((fu_indicator & F_NRI_MASK) | (b & NAL_TYPE_MASK), 1'b1, 1'b0, e && eop,
                 1'b0, 1'b0);
            frag_open = !(e && eop);
            end_bit_seen = e;
            kind = rhd_pkg::KIND_FU_DATA;
          end else if (frag_open) begin
            end_bit_seen = e;
            kind = rhd_pkg::KIND_FU_DATA;
            if (e && eop) begin
              note(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
              frag_open = 1'b0;
            end
          end else begin
            kind = rhd_pkg::KIND_NONE;
          end
        end
        rhd_pkg::KIND_FU_DATA: begin
          fin = eop && end_bit_seen;
          note(b, 1'b1, 1'b0, fin, 1'b0, 1'b0);
          if (fin) frag_open = 1'b0;
        end
        default: ;
      endcase
    end

    if (eop) begin
      pkt_pos = '0;
      kind = rhd_pkg::KIND_NONE;
      end_bit_seen = 1'b0;
    end else if (pos < rhd_pkg::BYTE_POS_MAX) begin
      pkt_pos = pos + 7'd1;
    end

    for (int i = 0; i < nal_burst.size(); i++) begin
      r = nal_burst[i];
      r.run_last = (i == nal_burst.size() - 1);
      annexb_expected.insert(annexb_expected.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Packet construction
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] v);
    frame_bytes.insert(frame_bytes.size(), v);
  endtask

  task automatic add_random(input int n);
    logic [7:0] v;
    for (int k = 0; k < n; k++) begin
      v = 8'($urandom_range(255));
      add_byte(v);
    end
  endtask

  // Open a packet: fixed header with random flags, the current sequence number,
  // then cc CSRC words. Advance the sequence number for the next packet.
  task automatic start_frame(input logic [3:0] cc);
    logic [7:0] b0;
    logic [7:0] b1;
    frame_bytes.delete();
    b0 = 8'($urandom_range(255));
    b1 = 8'($urandom_range(255));
    add_byte({b0[7:4], cc});
    add_byte(b1);
    add_byte(tx_seq[15:8]);
    add_byte(tx_seq[7:0]);
    add_random(8 + 4 * int'(cc));
    tx_seq = tx_seq + 16'd1;
  endtask

  // Queue the packet; a nonzero cut truncates it to that many bytes.
  task automatic commit_frame(input int cut);
    int        n;
    pkt_item_t it;
    n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      it.hold = 1'b0;
      it.data = frame_bytes[i];
      it.eop  = (i == n - 1);
      pkt_items.insert(pkt_items.size(), it);
    end
    planned_bytes += n;
  endtask

  task automatic queue_hold();
    pkt_item_t it;
    it.hold = 1'b1;
    it.data = 8'h00;
    it.eop  = 1'b0;
    pkt_items.insert(pkt_items.size(), it);
  endtask

  function automatic logic [3:0] pick_cc();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 4'd0;
    if (r < 92) return 4'($urandom_range(1, 3));
    return 4'($urandom_range(4, 15));
  endfunction

  task automatic emit_single();
    logic [7:0] hdr;
    logic [4:0] ntype;
    start_frame(pick_cc());
    hdr = 8'($urandom_range(255));
    ntype = 5'($urandom_range(0, 23));
    add_byte({hdr[7:5], ntype});
    add_random($urandom_range(0, 8));
    commit_frame(0);
  endtask

  // A fragmented NAL unit; now and then lose the start fragment or slip a
  // single NAL packet in between.
  task automatic emit_fu_run();
    int         frags;
    int         i;
    logic [7:0] ind;
    logic [7:0] hdr;
    logic [4:0] ftype;
    frags = $urandom_range(1, 4);
    hdr = 8'($urandom_range(255));
    ftype = hdr[4:0];
    for (i = ($urandom_range(9) == 0); i < frags; i++) begin
      if (i > 0 && $urandom_range(9) == 0) emit_single();
      start_frame(pick_cc());
      ind = 8'($urandom_range(255));
      hdr = 8'($urandom_range(255));
      add_byte({ind[7:5], rhd_pkg::NAL_TYPE_FU_A});
      add_byte({i == 0, i == frags - 1, hdr[5], ftype});
      add_random($urandom_range(0, 6));
      commit_frame(0);
    end
  endtask

  // Any type byte, any length, sometimes cut short anywhere
  task automatic emit_noise();
    int cut;
    start_frame(pick_cc());
    add_random($urandom_range(0, 9));
    cut = 0;
    if ($urandom_range(99) < 40) cut = $urandom_range(1, frame_bytes.size());
    commit_frame(cut);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge, hold the payload while stalled
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (drain_wait) begin
        // Hold off until every predicted result has been seen
        in_valid <= 1'b0;
        if (annexb_expected.size() == 0) drain_wait = 1'b0;
      end else if (pkt_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = pkt_items.pop_front();
        if (next_item.hold) begin
          drain_wait = 1'b1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_pkt_byte <= next_item.data;
          in_pkt_last <= next_item.eop;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Back-pressure on the result channel
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;

      // Compare the result transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        if (annexb_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %02h valid %0b",
                   $time, out_out_byte, out_out_valid);
          mismatches++;
        end else begin
          want_res = annexb_expected.pop_front();
          check_field("out_byte", want_res.data, out_out_byte);
          check_field("out_valid", want_res.data_valid, out_out_valid);
          check_field("nal_first", want_res.nal_first, out_nal_first);
          check_field("nal_last", want_res.nal_last, out_nal_last);
          check_field("nal_abort", want_res.nal_abort, out_nal_abort);
          check_field("seq_gap", want_res.seq_gap, out_seq_gap);
          check_field("run_last", want_res.run_last, out_run_last);
        end
      end

      // Predict from the packet byte transaction
      if (in_valid && !in_stall) begin
        depacketize_byte(in_pkt_byte, in_pkt_last);
        bytes_taken++;
      end

      // Watchdog: count cycles with no transaction on either channel
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  int pick;
  int jump;

  initial begin
    tx_seq = 16'hFFFE;

    // Single NAL with the lowest header byte, then type 23 with F/NRI set and no payload
    start_frame(4'd0); add_byte(8'h00); add_byte(8'hFF); commit_frame(0);
    start_frame(4'd0); add_byte(8'hF7); commit_frame(0);

    // FU-A start, middle and end; the sequence wraps to zero here
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h85); add_random(2); commit_frame(0);
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h05);
    add_byte(8'h00); add_byte(8'hFF); commit_frame(0);
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h45); add_random(1); commit_frame(0);

    // A type that gets dropped
    start_frame(4'd0); add_byte(8'h18); add_random(2); commit_frame(0);

    // Open a fragment, restart it with a fresh start bit, then cut in with a single NAL
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h85); add_random(1); commit_frame(0);
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h86); add_random(1); commit_frame(0);
    start_frame(4'd0); add_byte(8'h65); add_random(2); commit_frame(0);

    // Sequence gap while a fragment is open
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h85); commit_frame(0);
    tx_seq = tx_seq + 16'd5;
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h05); add_random(1); commit_frame(0);

    // Packet ending at the indicator, then an end bit with nothing behind it
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h81); add_random(1); commit_frame(0);
    start_frame(4'd0); add_byte(8'h7C); commit_frame(0);
    start_frame(4'd0); add_byte(8'h7C); add_byte(8'h41); commit_frame(0);

    // Header-only packet, then a packet cut inside its header
    start_frame(4'd0); commit_frame(0);
    start_frame(4'd0); add_byte(8'h65); commit_frame(5);

    // Full CSRC list, long enough to saturate the byte position
    start_frame(4'd15); add_byte(8'h65); add_random(58); commit_frame(0);
    queue_hold();

    // Random part: mostly well-formed runs, some gaps, repeats and noise
    while (planned_bytes < PLANNED_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        jump = $urandom_range(2, 300);
        tx_seq = tx_seq + jump[15:0];
      end else if (pick < 11) begin
        tx_seq = tx_seq - 16'd1;
      end
      pick = $urandom_range(99);
      if (pick < 35) emit_single();
      else if (pick < 80) emit_fu_run();
      else emit_noise();
    end

    // Hold reset, then release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last transaction and the last predicted result
    while (pkt_items.size() != 0 || in_valid || drain_wait || annexb_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
